// ===== rtl/eth_hp_pkg.sv =====
// types and constants shared by the ethernet / vlan / ip / udp header parser
package eth_hp_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned MAC_W    = 48;
    localparam int unsigned ADDR_W   = 64;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned IHB_W    = 6;
    localparam int unsigned TAG_W    = 2;

    localparam logic [POS_W-1:0]  POS_MAX      = 7'h7F;
    localparam logic [WORD_W-1:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [WORD_W-1:0] ETYPE_IPV6   = 16'h86DD;
    localparam logic [WORD_W-1:0] TPID_8021Q   = 16'h8100;
    localparam logic [WORD_W-1:0] TPID_8021AD  = 16'h88A8;
    localparam logic [DATA_W-1:0] PROTO_UDP    = 8'd17;
    localparam logic [3:0]        IP_VERSION_4 = 4'h4;
    localparam logic [IHB_W-1:0]  IPV4_MIN_HDR = 6'd20;

    // header byte offsets within each stage
    localparam logic [POS_W-1:0] ETH_SRC_OFF   = 7'd6;
    localparam logic [POS_W-1:0] ETH_TYPE_OFF  = 7'd12;
    localparam logic [POS_W-1:0] ETH_LAST_OFF  = 7'd13;
    localparam logic [POS_W-1:0] VLAN_TYPE_OFF = 7'd2;
    localparam logic [POS_W-1:0] VLAN_LAST_OFF = 7'd3;
    localparam logic [POS_W-1:0] IPV4_PROTO    = 7'd9;
    localparam logic [POS_W-1:0] IPV4_SRC_OFF  = 7'd12;
    localparam logic [POS_W-1:0] IPV4_DST_OFF  = 7'd16;
    localparam logic [POS_W-1:0] IPV4_END_OFF  = 7'd20;
    localparam logic [POS_W-1:0] IPV6_PROTO    = 7'd6;
    localparam logic [POS_W-1:0] IPV6_ADDR_OFF = 7'd8;
    localparam logic [POS_W-1:0] IPV6_END_OFF  = 7'd40;
    localparam logic [POS_W-1:0] IPV6_LAST_OFF = 7'd39;
    localparam logic [POS_W-1:0] UDP_WORDS_END = 7'd6;
    localparam logic [POS_W-1:0] UDP_LAST_OFF  = 7'd7;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FORMERR = 2'd1,
        ST_NOTIMP  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        STG_ETH  = 4'd0,
        STG_VLAN = 4'd1,
        STG_IPV4 = 4'd2,
        STG_IPV6 = 4'd3,
        STG_UDP  = 4'd4,
        STG_DONE = 4'd5,
        STG_HALT = 4'd6
    } t_stage;

    typedef struct packed {
        t_status             status;
        logic                is_ipv4;
        logic [MAC_W-1:0]    dst_mac;
        logic [MAC_W-1:0]    src_mac;
        logic [ADDR_W-1:0]   src_ip_high;
        logic [ADDR_W-1:0]   src_ip_low;
        logic [ADDR_W-1:0]   dst_ip_high;
        logic [ADDR_W-1:0]   dst_ip_low;
        logic [WORD_W-1:0]   src_port;
        logic [WORD_W-1:0]   dst_port;
        logic [WORD_W-1:0]   udp_length;
        logic [POS_W-1:0]    payload_offset;
    } t_result;

endpackage

// ===== rtl/eth_hp_in_if.sv =====
// frame byte channel: one byte per transfer with a last-byte mark
interface eth_hp_in_if;
    import eth_hp_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// ===== rtl/eth_hp_out_if.sv =====
// parse result channel: one transfer per frame
interface eth_hp_out_if;
    import eth_hp_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic              is_ipv4;
    logic [MAC_W-1:0]  dst_mac;
    logic [MAC_W-1:0]  src_mac;
    logic [ADDR_W-1:0] src_ip_high;
    logic [ADDR_W-1:0] src_ip_low;
    logic [ADDR_W-1:0] dst_ip_high;
    logic [ADDR_W-1:0] dst_ip_low;
    logic [WORD_W-1:0] src_port;
    logic [WORD_W-1:0] dst_port;
    logic [WORD_W-1:0] udp_length;
    logic [POS_W-1:0]  payload_offset;

    modport source (
        output valid, status, is_ipv4, dst_mac, src_mac, src_ip_high, src_ip_low,
               dst_ip_high, dst_ip_low, src_port, dst_port, udp_length, payload_offset,
        input  ready
    );
    modport sink (
        input  valid, status, is_ipv4, dst_mac, src_mac, src_ip_high, src_ip_low,
               dst_ip_high, dst_ip_low, src_port, dst_port, udp_length, payload_offset,
        output ready
    );
endinterface

// ===== rtl/eth_vlan_ip_udp_header_parser.sv =====
// streaming ethernet / vlan / ipv4 / ipv6 / udp header parser, top level
//
// Frame bytes enter one per transfer, from byte 0, with last_byte set on the
// final byte. Destination and source MACs and the ethertype are captured, up to
// MAX_VLAN_TAGS 802.1Q / 802.1ad tags are skipped, then an IPv4 header (version
// 4, IHL >= 5, options skipped) or a 40-byte IPv6 header is parsed, then the
// UDP ports and length. Exactly one result is given per frame, in the result
// register once its last byte leaves the input register; status is ok, format
// error (truncated or bad IPv4 header) or not implemented (other ethertype, too
// many tags, or not UDP), and every field other than status reads zero unless
// status is ok. The block takes one byte every cycle unless a last byte waits:
// each byte goes through an input register and a single pass of small compares
// and shifts into the parser state. Only a last byte waits, in the input register,
// while an earlier result is still held on the output; no byte is taken meanwhile.
module eth_vlan_ip_udp_header_parser #(
    parameter int unsigned MAX_VLAN_TAGS = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    eth_hp_in_if.sink           i_in,
    eth_hp_out_if.source        o_out
);
    import eth_hp_pkg::*;

    localparam logic [TAG_W-1:0] MaxTags = TAG_W'(MAX_VLAN_TAGS);

    // input register
    logic              r_in_valid;
    logic [DATA_W-1:0] r_in_data;
    logic              r_in_last;

    // parser state
    logic [POS_W-1:0]  r_pos,        n_pos;
    t_stage            r_stage,      n_stage;
    logic [TAG_W-1:0]  r_tag_count,  n_tag_count;
    logic [WORD_W-1:0] r_ether_type, n_ether_type;
    logic [IHB_W-1:0]  r_ihb,        n_ihb;
    logic [DATA_W-1:0] r_proto,      n_proto;
    logic              r_ipv4,       n_ipv4;
    logic [POS_W-1:0]  r_start,      n_start;
    logic [MAC_W-1:0]  r_mac  [2];
    logic [MAC_W-1:0]  n_mac  [2];
    logic [ADDR_W-1:0] r_addr [4];
    logic [ADDR_W-1:0] n_addr [4];
    logic [WORD_W-1:0] r_udp  [3];
    logic [WORD_W-1:0] n_udp  [3];
    t_status           r_status,     n_status;

    // result register
    logic              r_out_valid;
    t_result           r_out;
    t_result           n_out;

    logic              advance;
    logic [POS_W-1:0]  off;
    logic [POS_W-1:0] v6_rel;
    logic [POS_W-1:0]  next_start;
    logic [WORD_W-1:0] et_shift;
    logic              do_dispatch;
    logic              do_finish;
    logic              is_tag;
    t_status           final_status;

    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_comb begin
        off        = r_pos - r_start;
        v6_rel     = off - IPV6_ADDR_OFF;
        next_start = r_pos + POS_W'(1);
        et_shift   = {r_ether_type[WORD_W-DATA_W-1:0], r_in_data};
        is_tag     = (et_shift == TPID_8021Q) || (et_shift == TPID_8021AD);

        n_pos        = (r_pos != POS_MAX) ? r_pos + POS_W'(1) : r_pos;
        n_stage      = r_stage;
        n_tag_count  = r_tag_count;
        n_ether_type = r_ether_type;
        n_ihb        = r_ihb;
        n_proto      = r_proto;
        n_ipv4       = r_ipv4;
        n_start      = r_start;
        n_mac        = r_mac;
        n_addr       = r_addr;
        n_udp        = r_udp;
        n_status     = r_status;
        do_dispatch  = 1'b0;
        do_finish    = 1'b0;

        case (r_stage)
            STG_ETH: begin
                if (off < ETH_SRC_OFF) begin
                    n_mac[0] = {r_mac[0][MAC_W-DATA_W-1:0], r_in_data};
                end else if (off < ETH_TYPE_OFF) begin
                    n_mac[1] = {r_mac[1][MAC_W-DATA_W-1:0], r_in_data};
                end else begin
                    n_ether_type = et_shift;
                end
                do_dispatch = (off == ETH_LAST_OFF);
            end
            STG_VLAN: begin
                if (off >= VLAN_TYPE_OFF) begin
                    n_ether_type = et_shift;
                end
                do_dispatch = (off == VLAN_LAST_OFF);
            end
            STG_IPV4: begin
                if (off == '0) begin
                    n_ihb = {r_in_data[3:0], 2'b00};
                    if (r_in_data[7:4] != IP_VERSION_4 || n_ihb < IPV4_MIN_HDR) begin
                        n_status = ST_FORMERR;
                        n_stage  = STG_HALT;
                    end
                end else begin
                    if (off == IPV4_PROTO) begin
                        n_proto = r_in_data;
                    end else if (off >= IPV4_SRC_OFF && off < IPV4_DST_OFF) begin
                        n_addr[1] = {r_addr[1][ADDR_W-DATA_W-1:0], r_in_data};
                    end else if (off >= IPV4_DST_OFF && off < IPV4_END_OFF) begin
                        n_addr[3] = {r_addr[3][ADDR_W-DATA_W-1:0], r_in_data};
                    end
                    do_finish = ((off + POS_W'(1)) == {1'b0, r_ihb});
                end
            end
            STG_IPV6: begin
                if (off == IPV6_PROTO) begin
                    n_proto = r_in_data;
                end else if (off >= IPV6_ADDR_OFF && off < IPV6_END_OFF) begin
                    for (int k = 0; k < 4; k++) begin
                        if (v6_rel[4:3] == 2'(k)) begin
                            n_addr[k] = {r_addr[k][ADDR_W-DATA_W-1:0], r_in_data};
                        end
                    end
                end
                do_finish = (off == IPV6_LAST_OFF);
            end
            STG_UDP: begin
                if (off < UDP_WORDS_END) begin
                    for (int k = 0; k < 3; k++) begin
                        if (off[2:1] == 2'(k)) begin
                            n_udp[k] = {r_udp[k][WORD_W-DATA_W-1:0], r_in_data};
                        end
                    end
                end
                if (off == UDP_LAST_OFF) begin
                    n_stage = STG_DONE;
                    n_start = next_start;
                end
            end
            default: begin
            end
        endcase

        if (do_dispatch) begin
            if (is_tag && r_tag_count < MaxTags) begin
                n_tag_count = r_tag_count + TAG_W'(1);
                n_stage     = STG_VLAN;
                n_start     = next_start;
            end else if (et_shift == ETYPE_IPV4) begin
                n_ipv4  = 1'b1;
                n_stage = STG_IPV4;
                n_start = next_start;
            end else if (et_shift == ETYPE_IPV6) begin
                n_ipv4  = 1'b0;
                n_stage = STG_IPV6;
                n_start = next_start;
            end else begin
                n_status = ST_NOTIMP;
                n_stage  = STG_HALT;
            end
        end

        if (do_finish) begin
            if (n_proto == PROTO_UDP) begin
                n_stage = STG_UDP;
                n_start = next_start;
            end else begin
                n_status = ST_NOTIMP;
                n_stage  = STG_HALT;
            end
        end

        case (n_stage)
            STG_DONE: final_status = ST_OK;
            STG_HALT: final_status = n_status;
            default:  final_status = ST_FORMERR;
        endcase

        n_out        = '0;
        n_out.status = final_status;
        if (final_status == ST_OK) begin
            n_out.is_ipv4        = n_ipv4;
            n_out.dst_mac        = n_mac[0];
            n_out.src_mac        = n_mac[1];
            n_out.src_ip_high    = n_addr[0];
            n_out.src_ip_low     = n_addr[1];
            n_out.dst_ip_high    = n_addr[2];
            n_out.dst_ip_low     = n_addr[3];
            n_out.src_port       = n_udp[0];
            n_out.dst_port       = n_udp[1];
            n_out.udp_length     = n_udp[2];
            n_out.payload_offset = n_start;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_data <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    // parser state, cleared after the last byte of each frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in_last)) begin
            r_pos        <= '0;
            r_stage      <= STG_ETH;
            r_tag_count  <= '0;
            r_ether_type <= '0;
            r_ihb        <= '0;
            r_proto      <= '0;
            r_ipv4       <= 1'b0;
            r_start      <= '0;
            r_mac        <= '{default: '0};
            r_addr       <= '{default: '0};
            r_udp        <= '{default: '0};
            r_status     <= ST_OK;
        end else if (advance) begin
            r_pos        <= n_pos;
            r_stage      <= n_stage;
            r_tag_count  <= n_tag_count;
            r_ether_type <= n_ether_type;
            r_ihb        <= n_ihb;
            r_proto      <= n_proto;
            r_ipv4       <= n_ipv4;
            r_start      <= n_start;
            r_mac        <= n_mac;
            r_addr       <= n_addr;
            r_udp        <= n_udp;
            r_status     <= n_status;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in_last) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.is_ipv4        = r_out.is_ipv4;
    assign o_out.dst_mac        = r_out.dst_mac;
    assign o_out.src_mac        = r_out.src_mac;
    assign o_out.src_ip_high    = r_out.src_ip_high;
    assign o_out.src_ip_low     = r_out.src_ip_low;
    assign o_out.dst_ip_high    = r_out.dst_ip_high;
    assign o_out.dst_ip_low     = r_out.dst_ip_low;
    assign o_out.src_port       = r_out.src_port;
    assign o_out.dst_port       = r_out.dst_port;
    assign o_out.udp_length     = r_out.udp_length;
    assign o_out.payload_offset = r_out.payload_offset;

endmodule
